// File: rtl/l2ft_pkg.sv
// Package: types and constants of the layer-2 flow tracking table.
`default_nettype none
package l2ft_pkg;

    localparam logic [2:0] CMD_PACKET   = 3'd0;
    localparam logic [2:0] CMD_RESPONSE = 3'd1;
    localparam logic [2:0] CMD_TICK     = 3'd2;
    localparam logic [2:0] CMD_FDB      = 3'd3;
    localparam logic [2:0] CMD_OPEN     = 3'd4;
    localparam logic [2:0] CMD_CLOSE    = 3'd5;
    localparam logic [2:0] CMD_FLUSH    = 3'd6;

    localparam logic [2:0] EV_FDB    = 3'd0;
    localparam logic [2:0] EV_NEW    = 3'd1;
    localparam logic [2:0] EV_UPDATE = 3'd2;
    localparam logic [2:0] EV_DEL    = 3'd3;
    localparam logic [2:0] EV_RESET  = 3'd4;

    localparam logic [1:0] PH_CONFIRMED = 2'd0;
    localparam logic [1:0] PH_DENIED    = 2'd1;
    localparam logic [1:0] PH_OFFLOADED = 2'd2;
    localparam logic [1:0] PH_DYING     = 2'd3;

    localparam logic [15:0] DENIED_TICKS = 16'd10;

    localparam logic [1:0] CFG_MAX_FLOWS = 2'd0;
    localparam logic [1:0] CFG_CONF_TO   = 2'd1;
    localparam logic [1:0] CFG_DYING_TO  = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] ethertype;
        logic [15:0] vlan_tag;
        logic [15:0] in_port;
        logic [15:0] out_port;
        logic        offloaded;
        logic        denied;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [47:0] flow_src_mac;
        logic [47:0] flow_dst_mac;
        logic [15:0] flow_ethertype;
        logic [15:0] flow_vlan;
        logic [15:0] flow_in_port;
        logic [15:0] flow_out_port;
        logic        may_expire;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] ethertype;
        logic [15:0] vlan;
        logic [15:0] in_port;
        logic [15:0] out_port;
        logic [1:0]  phase;
        logic [15:0] timer;
        logic        running;
    } entry_t;

    // command broadcast to all cells
    typedef struct packed {
        logic        shift;    // rotate the ring by one
        logic        hit_upd;  // apply packet / response to matching cell
        logic        ins;      // write new entry into head cell
        in_item_t    item;
        logic [15:0] conf_to;
        logic [15:0] dying_to;
    } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/l2ft_cell.sv
// One table cell: holds an entry, compares the key, applies per-entry updates.
`default_nettype none
module l2ft_cell
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  l2ft_pkg::cell_ctl_t  ctl,
    input  l2ft_pkg::entry_t     prev_in,
    input  wire                  head,
    input  wire                  walk_tick,
    input  wire                  walk_close,
    input  wire                  flush,
    output l2ft_pkg::entry_t     cur,
    output logic                 key_hit,
    output logic                 src_off
);
    l2ft_pkg::entry_t e_reg;
    l2ft_pkg::entry_t e_next;
    logic             v_reg;
    l2ft_pkg::entry_t w;

    always_comb
    begin
        cur = e_reg;
        cur.valid = v_reg;
        key_hit = v_reg && e_reg.src_mac == ctl.item.src_mac
                  && e_reg.dst_mac == ctl.item.dst_mac
                  && e_reg.ethertype == ctl.item.ethertype
                  && e_reg.vlan == ctl.item.vlan_tag;
        src_off = v_reg && e_reg.src_mac == ctl.item.src_mac
                  && e_reg.phase == l2ft_pkg::PH_OFFLOADED;
    end

    // walks act on the entry arriving from the neighbor as it passes
    always_comb
    begin
        w = prev_in;
        if (walk_tick && w.valid && w.running)
        begin
            if (w.timer > 16'd1)
                w.timer = w.timer - 16'd1;
            else if (w.phase == l2ft_pkg::PH_DYING)
            begin
                w.valid = 1'b0;
                w.running = 1'b0;
            end
            else
            begin
                w.phase = l2ft_pkg::PH_DYING;
                w.timer = ctl.dying_to;
            end
        end
        if (walk_close && w.valid && w.phase == l2ft_pkg::PH_OFFLOADED)
        begin
            w.phase = l2ft_pkg::PH_DYING;
            w.timer = ctl.dying_to;
            w.running = 1'b1;
        end
        e_next = cur;
        if (ctl.shift)
            e_next = w;
        else if (ctl.ins && head)
        begin
            e_next.valid = 1'b1;
            e_next.src_mac = ctl.item.src_mac;
            e_next.dst_mac = ctl.item.dst_mac;
            e_next.ethertype = ctl.item.ethertype;
            e_next.vlan = ctl.item.vlan_tag;
            e_next.in_port = ctl.item.in_port;
            e_next.out_port = ctl.item.out_port;
            e_next.phase = l2ft_pkg::PH_CONFIRMED;
            e_next.timer = ctl.conf_to;
            e_next.running = 1'b1;
        end
        else if (ctl.hit_upd && key_hit)
        begin
            if (ctl.item.command == l2ft_pkg::CMD_PACKET)
            begin
                e_next.in_port = ctl.item.in_port;
                e_next.out_port = ctl.item.out_port;
            end
            else if (ctl.item.offloaded)
            begin
                e_next.phase = l2ft_pkg::PH_OFFLOADED;
                e_next.running = 1'b0;
            end
            else if (ctl.item.denied)
            begin
                e_next.phase = l2ft_pkg::PH_DENIED;
                e_next.timer = l2ft_pkg::DENIED_TICKS;
                e_next.running = 1'b1;
            end
        end
        if (flush)
            e_next.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= e_next.valid;
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end
endmodule
`default_nettype wire

// File: rtl/l2_flow_tracking_table_unit.sv
// Top level: layer-2 flow tracking table as a ring of entry cells.
// Packet, response, fdb query, open, flush: the accepted item is registered, evaluated in ST_EVAL,
// and any result is registered for output; a new item is taken only after any result has been taken.
// Tick and client close rotate the ring once in ST_WALK; a tick walk gives at most one DEL per cycle when not stalled.
// A stalled result holds the walk; the input stalls until the result is taken.
// Reset clears all valid bits, flow count, client state and config to defaults.
`default_nettype none
module l2_flow_tracking_table_unit
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  l2ft_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  wire                  out_stall,
    output l2ft_pkg::out_item_t  out_item,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [1:0]           cfg_index,
    input  wire  [15:0]          cfg_data
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_WALK = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    l2ft_pkg::in_item_t  item_reg;
    logic [4:0]          max_reg;
    logic [15:0]         conf_reg, dying_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                client_reg, client_next;
    logic [IW:0]         step_reg, step_next;
    logic [4:0]          ndel_reg, ndel_next;
    logic                ov_reg, ov_next;
    l2ft_pkg::out_item_t ob_reg, ob_next;

    l2ft_pkg::cell_ctl_t ctl;
    l2ft_pkg::entry_t    ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit, soff;
    logic                walk_tick, walk_close, flush;

    logic [TABLE_DEPTH-1:0] lowfree;
    logic [IW-1:0]          hidx;
    logic                   anyhit;
    logic                   more_del;

    // ring: head cell is index TABLE_DEPTH-1, receives from it shifting toward 0
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            l2ft_pkg::entry_t pin;
            assign pin = ent[(g + 1) % TABLE_DEPTH];
            l2ft_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_in    (pin),
                .head       (lowfree[g]),
                .walk_tick  (walk_tick && g == TABLE_DEPTH - 1),
                .walk_close (walk_close && g == TABLE_DEPTH - 1),
                .flush      (flush),
                .cur        (ent[g]),
                .key_hit    (hit[g]),
                .src_off    (soff[g])
            );
        end
    endgenerate

    always_comb
    begin
        lowfree = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--)
            if (!ent[k].valid)
                lowfree = TABLE_DEPTH'(1) << k;
        hidx = '0;
        anyhit = |hit;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--)
            if (hit[k])
                hidx = IW'(k);
        // another expiring entry still ahead of the wrap point in this walk
        more_del = 1'b0;
        for (int k = 1; k < TABLE_DEPTH; k++)
            if (k + int'(step_reg) < TABLE_DEPTH && ent[k].valid && ent[k].running
                && ent[k].timer <= 16'd1)
                more_del = 1'b1;
    end

    l2ft_pkg::entry_t wrap_e;
    logic [CW-1:0]    limit;
    always_comb
    begin
        wrap_e = ent[0];
        limit = (int'(max_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(max_reg);
    end

    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_item  = ob_reg;

    logic accept;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        client_next = client_reg;
        step_next   = step_reg;
        ndel_next   = ndel_reg;
        ov_next     = ov_reg && out_stall;
        ob_next     = ob_reg;
        ctl.shift   = 1'b0;
        ctl.hit_upd = 1'b0;
        ctl.ins     = 1'b0;
        ctl.item    = item_reg;
        ctl.conf_to = conf_reg;
        ctl.dying_to = dying_reg;
        walk_tick   = 1'b0;
        walk_close  = 1'b0;
        flush       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                ob_next = '0;
                ob_next.last = 1'b1;
                state_next = ST_IDLE;
                unique case (item_reg.command)
                    l2ft_pkg::CMD_PACKET:
                    begin
                        if (!anyhit)
                        begin
                            if (count_reg < limit && |lowfree)
                            begin
                                ctl.ins = 1'b1;
                                count_next = count_reg + CW'(1);
                                ob_next.event_kind = l2ft_pkg::EV_NEW;
                                ob_next.flow_src_mac = item_reg.src_mac;
                                ob_next.flow_dst_mac = item_reg.dst_mac;
                                ob_next.flow_ethertype = item_reg.ethertype;
                                ob_next.flow_vlan = item_reg.vlan_tag;
                                ob_next.flow_in_port = item_reg.in_port;
                                ob_next.flow_out_port = item_reg.out_port;
                                ov_next = client_reg;
                            end
                        end
                        else if (ent[hidx].in_port != item_reg.in_port
                                 || ent[hidx].out_port != item_reg.out_port)
                        begin
                            ctl.hit_upd = 1'b1;
                            ob_next.event_kind = l2ft_pkg::EV_UPDATE;
                            ob_next.flow_src_mac = item_reg.src_mac;
                            ob_next.flow_dst_mac = item_reg.dst_mac;
                            ob_next.flow_ethertype = item_reg.ethertype;
                            ob_next.flow_vlan = item_reg.vlan_tag;
                            ob_next.flow_in_port = item_reg.in_port;
                            ob_next.flow_out_port = item_reg.out_port;
                            ov_next = ent[hidx].phase != l2ft_pkg::PH_DYING;
                        end
                    end
                    l2ft_pkg::CMD_RESPONSE: ctl.hit_upd = 1'b1;
                    l2ft_pkg::CMD_FDB:
                    begin
                        ob_next.event_kind = l2ft_pkg::EV_FDB;
                        ob_next.flow_src_mac = item_reg.src_mac;
                        ob_next.may_expire = ~|soff;
                        ov_next = 1'b1;
                    end
                    l2ft_pkg::CMD_OPEN: client_next = 1'b1;
                    l2ft_pkg::CMD_TICK, l2ft_pkg::CMD_CLOSE:
                    begin
                        if (item_reg.command == l2ft_pkg::CMD_CLOSE)
                            client_next = 1'b0;
                        step_next = '0;
                        ndel_next = '0;
                        state_next = ST_WALK;
                    end
                    l2ft_pkg::CMD_FLUSH:
                    begin
                        flush = 1'b1;
                        count_next = '0;
                        ob_next.event_kind = l2ft_pkg::EV_RESET;
                        ov_next = client_reg;
                    end
                    default: ;
                endcase
            end
            ST_WALK:
            begin
                // slot order is cell order 0..N-1; cell 0 wraps to the head
                if (!ov_reg || !out_stall)
                begin
                    if (step_reg == (IW+1)'(TABLE_DEPTH))
                        state_next = ST_IDLE;
                    else
                    begin
                        ctl.shift = 1'b1;
                        walk_tick = item_reg.command == l2ft_pkg::CMD_TICK;
                        walk_close = item_reg.command == l2ft_pkg::CMD_CLOSE;
                        step_next = step_reg + (IW+1)'(1);
                        if (walk_tick && wrap_e.valid && wrap_e.running
                            && wrap_e.timer <= 16'd1)
                        begin
                            if (wrap_e.phase == l2ft_pkg::PH_DYING && count_reg != '0)
                                count_next = count_reg - CW'(1);
                            if (ndel_reg < 5'd16)
                            begin
                                ndel_next = ndel_reg + 5'd1;
                                ob_next = '0;
                                ob_next.event_kind = l2ft_pkg::EV_DEL;
                                ob_next.flow_src_mac = wrap_e.src_mac;
                                ob_next.flow_dst_mac = wrap_e.dst_mac;
                                ob_next.flow_ethertype = wrap_e.ethertype;
                                ob_next.flow_vlan = wrap_e.vlan;
                                ob_next.flow_in_port = wrap_e.in_port;
                                ob_next.flow_out_port = wrap_e.out_port;
                                ob_next.last = !more_del || ndel_reg == 5'd15;
                                ov_next = 1'b1;
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            client_reg <= 1'b0;
            ov_reg     <= 1'b0;
            step_reg   <= '0;
            ndel_reg   <= '0;
            max_reg    <= 5'd16;
            conf_reg   <= 16'd30;
            dying_reg  <= 16'd10;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            client_reg <= client_next;
            ov_reg     <= ov_next;
            step_reg   <= step_next;
            ndel_reg   <= ndel_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    l2ft_pkg::CFG_MAX_FLOWS: max_reg <= cfg_data[4:0];
                    l2ft_pkg::CFG_CONF_TO:   conf_reg <= cfg_data;
                    l2ft_pkg::CFG_DYING_TO:  dying_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        if (accept)
            item_reg <= in_item;
    end
endmodule
`default_nettype wire

// File: tb/l2ft_checker.sv
// Checker: predicts the flow table's events from accepted items and compares them.
`default_nettype none
module l2ft_checker
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire                  in_stall,
    input  l2ft_pkg::in_item_t   in_item,
    input  wire                  out_valid,
    input  wire                  out_stall,
    input  l2ft_pkg::out_item_t  out_item,
    input  wire                  cfg_valid,
    input  wire                  cfg_ready,
    input  wire [1:0]            cfg_index,
    input  wire [15:0]           cfg_data,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    l2ft_pkg::entry_t    flows [DEPTH];
    logic [4:0]          max_flows;
    logic [15:0]         conf_to;
    logic [15:0]         dying_to;
    int                  flow_count;
    bit                  attached;
    l2ft_pkg::out_item_t expected_events [$];

    assign pending = expected_events.size();

    function automatic l2ft_pkg::out_item_t entry_event(logic [2:0] kind,
                                                       l2ft_pkg::entry_t e);
        l2ft_pkg::out_item_t r;
        r = '0;
        r.event_kind = kind;
        r.flow_src_mac = e.src_mac;
        r.flow_dst_mac = e.dst_mac;
        r.flow_ethertype = e.ethertype;
        r.flow_vlan = e.vlan;
        r.flow_in_port = e.in_port;
        r.flow_out_port = e.out_port;
        return r;
    endfunction

    task automatic apply_item(l2ft_pkg::in_item_t it);
        l2ft_pkg::out_item_t evs [$];
        l2ft_pkg::out_item_t r;
        int hit;
        int limit;
        int slot;
        bit may;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && flows[i].valid && flows[i].src_mac == it.src_mac
                && flows[i].dst_mac == it.dst_mac && flows[i].ethertype == it.ethertype
                && flows[i].vlan == it.vlan_tag)
                hit = i;
        case (it.command)
            l2ft_pkg::CMD_PACKET:
                if (hit < 0)
                begin
                    limit = (max_flows < DEPTH) ? max_flows : DEPTH;
                    slot = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!flows[i].valid)
                            slot = i;
                    if (flow_count < limit && slot >= 0)
                    begin
                        flows[slot].valid = 1'b1;
                        flows[slot].src_mac = it.src_mac;
                        flows[slot].dst_mac = it.dst_mac;
                        flows[slot].ethertype = it.ethertype;
                        flows[slot].vlan = it.vlan_tag;
                        flows[slot].in_port = it.in_port;
                        flows[slot].out_port = it.out_port;
                        flows[slot].phase = l2ft_pkg::PH_CONFIRMED;
                        flows[slot].timer = conf_to;
                        flows[slot].running = 1'b1;
                        flow_count++;
                        if (attached)
                            evs.push_back(entry_event(l2ft_pkg::EV_NEW, flows[slot]));
                    end
                end
                else if (flows[hit].in_port != it.in_port
                         || flows[hit].out_port != it.out_port)
                begin
                    flows[hit].in_port = it.in_port;
                    flows[hit].out_port = it.out_port;
                    if (flows[hit].phase != l2ft_pkg::PH_DYING)
                        evs.push_back(entry_event(l2ft_pkg::EV_UPDATE, flows[hit]));
                end
            l2ft_pkg::CMD_RESPONSE:
                if (hit >= 0)
                begin
                    if (it.offloaded)
                    begin
                        flows[hit].phase = l2ft_pkg::PH_OFFLOADED;
                        flows[hit].running = 1'b0;
                    end
                    else if (it.denied)
                    begin
                        flows[hit].phase = l2ft_pkg::PH_DENIED;
                        flows[hit].timer = l2ft_pkg::DENIED_TICKS;
                        flows[hit].running = 1'b1;
                    end
                end
            l2ft_pkg::CMD_TICK:
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!flows[i].valid || !flows[i].running)
                        continue;
                    if (flows[i].timer > 1)
                    begin
                        flows[i].timer--;
                        continue;
                    end
                    if (evs.size() < 16)
                        evs.push_back(entry_event(l2ft_pkg::EV_DEL, flows[i]));
                    if (flows[i].phase == l2ft_pkg::PH_DYING)
                    begin
                        flows[i].valid = 1'b0;
                        flows[i].running = 1'b0;
                        if (flow_count > 0)
                            flow_count--;
                    end
                    else
                    begin
                        flows[i].phase = l2ft_pkg::PH_DYING;
                        flows[i].timer = dying_to;
                    end
                end
            l2ft_pkg::CMD_FDB:
            begin
                may = 1'b1;
                for (int i = 0; i < DEPTH; i++)
                    if (flows[i].valid && flows[i].src_mac == it.src_mac
                        && flows[i].phase == l2ft_pkg::PH_OFFLOADED)
                        may = 1'b0;
                r = '0;
                r.event_kind = l2ft_pkg::EV_FDB;
                r.flow_src_mac = it.src_mac;
                r.may_expire = may;
                evs.push_back(r);
            end
            l2ft_pkg::CMD_OPEN:
                attached = 1'b1;
            l2ft_pkg::CMD_CLOSE:
            begin
                attached = 1'b0;
                for (int i = 0; i < DEPTH; i++)
                    if (flows[i].valid && flows[i].phase == l2ft_pkg::PH_OFFLOADED)
                    begin
                        flows[i].phase = l2ft_pkg::PH_DYING;
                        flows[i].timer = dying_to;
                        flows[i].running = 1'b1;
                    end
            end
            l2ft_pkg::CMD_FLUSH:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    flows[i].valid = 1'b0;
                    flows[i].running = 1'b0;
                end
                flow_count = 0;
                if (attached)
                begin
                    r = '0;
                    r.event_kind = l2ft_pkg::EV_RESET;
                    evs.push_back(r);
                end
            end
            default: ;
        endcase
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[k])
            expected_events.push_back(evs[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (flows[i])
                flows[i] = '0;
            max_flows = 5'd16;
            conf_to = 16'd30;
            dying_to = 16'd10;
            flow_count = 0;
            attached = 1'b0;
            errors = 0;
            expected_events.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    l2ft_pkg::CFG_MAX_FLOWS: max_flows = cfg_data[4:0];
                    l2ft_pkg::CFG_CONF_TO:   conf_to = cfg_data;
                    l2ft_pkg::CFG_DYING_TO:  dying_to = cfg_data;
                    default: ;
                endcase
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event expected none actual %h",
                             $time, out_item);
                    errors++;
                end
                else if (expected_events[0] !== out_item)
                begin
                    $display("%0t: event mismatch expected %h actual %h",
                             $time, expected_events[0], out_item);
                    errors++;
                    void'(expected_events.pop_front());
                end
                else
                    void'(expected_events.pop_front());
            end
            if (in_valid && !in_stall)
                apply_item(in_item);
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_l2_flow_tracking_table_unit.sv
// Testbench top: drives the flow table with directed and random items and gives the verdict.
`default_nettype none
module tb_l2_flow_tracking_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    l2ft_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    l2ft_pkg::out_item_t out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_data = '0;
    int                  errors;
    int                  pending;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    bit                  hold_off = 1'b0;
    bit                  done = 1'b0;
    logic [47:0]         mac_pool [4];

    always #1 clk = ~clk;

    l2_flow_tracking_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    l2ft_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);

    // valid stays up between back-to-back items; idle cycles and other users drop it
    task automatic send_item(l2ft_pkg::in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic l2ft_pkg::in_item_t flow_item(logic [2:0] cmd, int k);
        l2ft_pkg::in_item_t it;
        it = '0;
        it.command = cmd;
        it.src_mac = mac_pool[k % 4];
        it.dst_mac = mac_pool[(k / 4) % 4];
        it.ethertype = (k & 8) ? 16'h86DD : 16'h0800;
        it.vlan_tag = (k & 16) ? 16'd5 : 16'hFFFF;
        it.in_port = 16'($urandom_range(3));
        it.out_port = 16'($urandom_range(3));
        it.offloaded = 1'($urandom);
        it.denied = 1'($urandom);
        return it;
    endfunction

    function automatic l2ft_pkg::in_item_t random_item();
        l2ft_pkg::in_item_t it;
        logic [191:0]       raw;
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(l2ft_pkg::in_item_t)-1:0];
            if (it.command == 3'd7 && $urandom_range(1))
                it.command = l2ft_pkg::CMD_FDB;
            return it;
        end
        it = flow_item(l2ft_pkg::CMD_PACKET, $urandom_range(31));
        if (r < 50) it.command = l2ft_pkg::CMD_PACKET;
        else if (r < 68) it.command = l2ft_pkg::CMD_RESPONSE;
        else if (r < 86) it.command = l2ft_pkg::CMD_TICK;
        else if (r < 92) it.command = l2ft_pkg::CMD_FDB;
        else if (r < 95) it.command = l2ft_pkg::CMD_OPEN;
        else if (r < 98) it.command = l2ft_pkg::CMD_CLOSE;
        else it.command = l2ft_pkg::CMD_FLUSH;
        return it;
    endfunction

    initial
    begin
        l2ft_pkg::in_item_t it;
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        mac_pool[2] = 48'h0200_0000_0001;
        mac_pool[3] = 48'($urandom) | 48'h5555_0000_0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: timeouts short so expiry is seen
        write_reg(l2ft_pkg::CFG_CONF_TO, 16'd2);
        write_reg(l2ft_pkg::CFG_DYING_TO, 16'd0);
        it = '0; it.command = l2ft_pkg::CMD_FLUSH; send_item(it);
        it.command = l2ft_pkg::CMD_OPEN; send_item(it);
        send_item(it);
        it = '1; it.command = l2ft_pkg::CMD_PACKET; send_item(it);
        it.in_port = 16'h0; send_item(it);
        send_item(it);
        it = '0; it.command = l2ft_pkg::CMD_PACKET; send_item(it);
        it.command = l2ft_pkg::CMD_RESPONSE; it.offloaded = 1'b1; send_item(it);
        it.command = l2ft_pkg::CMD_FDB; send_item(it);
        it = '1; it.command = l2ft_pkg::CMD_RESPONSE; it.offloaded = 1'b0; send_item(it);
        it.offloaded = 1'b0; it.denied = 1'b0; it.command = l2ft_pkg::CMD_RESPONSE;
        send_item(it);
        it = '0; it.command = l2ft_pkg::CMD_TICK; send_item(it);
        send_item(it);
        it = '1; it.command = l2ft_pkg::CMD_PACKET; it.in_port = 16'h7; send_item(it);
        it = '0; it.command = l2ft_pkg::CMD_CLOSE; send_item(it);
        it.command = l2ft_pkg::CMD_TICK; send_item(it);
        send_item(it);
        it.command = l2ft_pkg::CMD_FDB; it.src_mac = '1; send_item(it);
        it.command = 3'd7; send_item(it);
        it.command = l2ft_pkg::CMD_FLUSH; send_item(it);
        it.command = l2ft_pkg::CMD_OPEN; send_item(it);
        it.command = l2ft_pkg::CMD_FLUSH; send_item(it);

        write_reg(l2ft_pkg::CFG_MAX_FLOWS, 16'd0);
        it = flow_item(l2ft_pkg::CMD_PACKET, 3); send_item(it);
        write_reg(l2ft_pkg::CFG_MAX_FLOWS, 16'd31);
        write_reg(l2ft_pkg::CFG_CONF_TO, 16'hFFFF);
        write_reg(l2ft_pkg::CFG_DYING_TO, 16'hFFFF);
        for (int k = 0; k < 20; k++)
            send_item(flow_item(l2ft_pkg::CMD_PACKET, k));
        it = '0; it.command = l2ft_pkg::CMD_TICK; send_item(it);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                3: begin send_idle_pct = 21; stall_pct = 21; end
                default: begin send_idle_pct = 0; stall_pct = 10; end
            endcase
            write_reg(l2ft_pkg::CFG_MAX_FLOWS, 16'($urandom_range(1, 20)));
            write_reg(l2ft_pkg::CFG_CONF_TO, 16'($urandom_range(0, 6)));
            write_reg(l2ft_pkg::CFG_DYING_TO, 16'($urandom_range(0, 4)));
            if (phase == 4)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 55; n++)
                send_item(random_item());
        end
        in_valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        done = 1'b1;
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        if (!done)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
`default_nettype wire
